[rtl/sisr_pkg.sv]
// shared types and constants for the serial-in latched shift register
package sisr_pkg;

    typedef logic [1:0] t_level;

    localparam t_level LVL_LOW      = 2'd0;
    localparam t_level LVL_HIGH     = 2'd1;
    localparam t_level LVL_FLOAT    = 2'd2;
    localparam t_level LVL_CONFLICT = 2'd3;

    localparam int unsigned NUM_BITS = 8;

    typedef logic [1:0] t_cfg_index;

    localparam t_cfg_index CFG_CLOCK_ACTIVE_HIGH = 2'd0;
    localparam t_cfg_index CFG_OE_HIGH_EN        = 2'd1;
    localparam t_cfg_index CFG_MR_HIGH_CLR       = 2'd2;

    typedef struct packed {
        logic clock_active_high;
        logic oe_high_en;
        logic mr_high_clr;
    } t_cfg;

    typedef struct packed {
        t_level srclk_level;
        t_level rclk_level;
        t_level mr_level;
        t_level ser_level;
        t_level oe_level;
    } t_in_item;

    typedef struct packed {
        t_level q0_level;
        t_level q1_level;
        t_level q2_level;
        t_level q3_level;
        t_level q4_level;
        t_level q5_level;
        t_level q6_level;
        t_level q7_level;
        t_level serial_out_level;
    } t_out_item;

endpackage

[rtl/sisr_core.sv]
// shift and storage state with the per-sample update and output decode
module sisr_core
    import sisr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_adv,
    input  t_in_item  i_item,
    output t_out_item o_result
);

    logic [NUM_BITS-1:0] r_shift_bits, n_shift_bits;
    logic [NUM_BITS-1:0] r_shift_mask, n_shift_mask;
    logic [NUM_BITS-1:0] r_latch_bits, n_latch_bits;
    logic [NUM_BITS-1:0] r_latch_mask, n_latch_mask;
    t_level              r_prev_sclk, n_prev_sclk;
    t_level              r_prev_lclk, n_prev_lclk;

    t_level act, inact, mr_act, oe_act;
    t_level sclk, lclk;
    t_level q [NUM_BITS];

    always_comb begin
        act    = i_cfg.clock_active_high ? LVL_HIGH : LVL_LOW;
        inact  = i_cfg.clock_active_high ? LVL_LOW  : LVL_HIGH;
        mr_act = i_cfg.mr_high_clr       ? LVL_HIGH : LVL_LOW;
        oe_act = i_cfg.oe_high_en        ? LVL_HIGH : LVL_LOW;
        // floating clocks read as inactive
        sclk   = (i_item.srclk_level == LVL_FLOAT) ? inact : i_item.srclk_level;
        lclk   = (i_item.rclk_level  == LVL_FLOAT) ? inact : i_item.rclk_level;

        n_latch_bits = r_latch_bits;
        n_latch_mask = r_latch_mask;
        if (lclk == act && r_prev_lclk == inact) begin
            n_latch_bits = r_shift_bits;
            n_latch_mask = r_shift_mask;
        end else if (lclk == LVL_CONFLICT) begin
            n_latch_mask = '1;
        end

        n_shift_bits = r_shift_bits;
        n_shift_mask = r_shift_mask;
        if (i_item.mr_level == mr_act) begin
            n_shift_bits = '0;
            n_shift_mask = '0;
        end else if (i_item.mr_level == LVL_CONFLICT || sclk == LVL_CONFLICT) begin
            n_shift_mask = '1;
        end else if (sclk == act && r_prev_sclk == inact) begin
            n_shift_bits = {r_shift_bits[NUM_BITS-2:0], i_item.ser_level == LVL_HIGH};
            n_shift_mask = {r_shift_mask[NUM_BITS-2:0], i_item.ser_level == LVL_CONFLICT};
        end

        n_prev_sclk = sclk;
        n_prev_lclk = lclk;

        // output enable floating counts as enabled
        for (int i = 0; i < NUM_BITS; i++) begin
            if (i_item.oe_level == LVL_CONFLICT) begin
                q[i] = LVL_CONFLICT;
            end else if (i_item.oe_level != LVL_FLOAT && i_item.oe_level != oe_act) begin
                q[i] = LVL_FLOAT;
            end else if (n_latch_mask[i]) begin
                q[i] = LVL_CONFLICT;
            end else begin
                q[i] = {1'b0, n_latch_bits[i]};
            end
        end

        o_result.q0_level = q[0];
        o_result.q1_level = q[1];
        o_result.q2_level = q[2];
        o_result.q3_level = q[3];
        o_result.q4_level = q[4];
        o_result.q5_level = q[5];
        o_result.q6_level = q[6];
        o_result.q7_level = q[7];
        o_result.serial_out_level = n_shift_mask[NUM_BITS-1] ? LVL_CONFLICT
                                  : {1'b0, n_shift_bits[NUM_BITS-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_bits <= '0;
            r_shift_mask <= '0;
            r_latch_bits <= '0;
            r_latch_mask <= '0;
            r_prev_sclk  <= LVL_LOW;
            r_prev_lclk  <= LVL_LOW;
        end else if (i_adv) begin
            r_shift_bits <= n_shift_bits;
            r_shift_mask <= n_shift_mask;
            r_latch_bits <= n_latch_bits;
            r_latch_mask <= n_latch_mask;
            r_prev_sclk  <= n_prev_sclk;
            r_prev_lclk  <= n_prev_lclk;
        end
    end

endmodule

[rtl/serial_in_latched_shift_register.sv]
// top level: pin sample transfers in, q and serial output levels out
// An 8-bit serial-in shift register with a storage latch, evaluated on
// four-valued pin levels (low, high, floating, conflict). Each input transfer
// is one sample of SRCLK, RCLK, MR, SER and OE; each produces exactly one
// result transfer with the eight gated Q levels and the serial output level,
// as they stand after that sample. A sample is captured in an input register,
// then evaluated and written to the result register once that one is free or
// being taken; throughput is one sample per cycle when the result side
// keeps taking. The clock, OE and MR polarities are configured through the
// config port (index 0 clock edge, 1 OE polarity, 2 MR polarity; index 3 is
// ignored, data bit 0 is used). The config port always takes a transfer;
// write it only while no sample is in flight.
module serial_in_latched_shift_register
    import sisr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // config write channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  t_cfg_index i_cfg_index,
    input  logic       i_cfg_data,
    // pin sample channel
    input  logic       i_valid,
    output logic       o_ready,
    input  t_in_item   i_item,
    // result channel
    output logic       o_valid,
    input  logic       i_ready,
    output t_out_item  o_result
);

    // config registers
    t_cfg      r_cfg;

    // input stage
    logic      r_in_vld;
    t_in_item  r_in;

    // result stage
    logic      r_out_vld;
    t_out_item r_out;

    // evaluated result of the sample held in the input stage
    t_out_item core_result;

    // sample moves from the input stage into the result register
    logic adv;

    assign adv         = r_in_vld && (!r_out_vld || i_ready);
    // input stage takes a new transfer when empty or emptying this cycle
    assign o_ready     = !r_in_vld || adv;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_vld;
    assign o_result    = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clock_active_high <= 1'b1;
            r_cfg.oe_high_en        <= 1'b0;
            r_cfg.mr_high_clr       <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CLOCK_ACTIVE_HIGH: r_cfg.clock_active_high <= i_cfg_data;
                CFG_OE_HIGH_EN:        r_cfg.oe_high_en        <= i_cfg_data;
                CFG_MR_HIGH_CLR:       r_cfg.mr_high_clr       <= i_cfg_data;
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_item;
        end
    end

    // state update and output decode
    sisr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_adv    (adv),
        .i_item   (r_in),
        .o_result (core_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= core_result;
        end
    end

    // a sample that advances shows up as a result on the next cycle
    a_adv_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_vld)
        else $error("advanced sample did not reach result register");

    // serial output is never floating
    a_sout_not_float: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out.serial_out_level != LVL_FLOAT))
        else $error("serial output reads floating");

    // conflicting oe forces every q to conflict; checked on q0 and q7
    a_oe_conflict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in.oe_level == LVL_CONFLICT) |=>
            (r_out.q0_level == LVL_CONFLICT && r_out.q7_level == LVL_CONFLICT))
        else $error("oe conflict not propagated to q outputs");

    // a stalled input side always means a held sample
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_in_vld && r_out_vld && !i_ready))
        else $error("input stalled without a blocked sample");

endmodule

[sim/serial_in_latched_shift_register_tb.sv]
// testbench for the serial-in latched shift register: pin samples in, predicted q levels checked
module serial_in_latched_shift_register_tb
    import sisr_pkg::*;
;

    // cycle budget: ~1850 samples under worst-case gaps and stalls, with ample margin
    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int NUM_PHASES = 12;

    // index past the three registers, the block must ignore it
    localparam t_cfg_index CFG_SPARE_INDEX = 2'd3;

    // scoreboard: own copy of the register state, predicts the levels of each sample
    class level_scoreboard;
        t_cfg       cfg;
        logic [7:0] shift_bits;
        logic [7:0] shift_x_mask;
        logic [7:0] latch_bits;
        logic [7:0] latch_x_mask;
        t_level     prev_shift_clk;
        t_level     prev_store_clk;
        t_out_item  expected_levels[$];
        int         mismatches;

        function new();
            cfg.clock_active_high = 1'b1;
            cfg.oe_high_en        = 1'b0;
            cfg.mr_high_clr       = 1'b0;
            shift_bits     = '0;
            shift_x_mask   = '0;
            latch_bits     = '0;
            latch_x_mask   = '0;
            prev_shift_clk = LVL_LOW;
            prev_store_clk = LVL_LOW;
            mismatches     = 0;
        endfunction

        function int pending();
            return expected_levels.size();
        endfunction

        function void write_reg(t_cfg_index idx, logic data);
            case (idx)
                CFG_CLOCK_ACTIVE_HIGH: cfg.clock_active_high = data;
                CFG_OE_HIGH_EN:        cfg.oe_high_en = data;
                CFG_MR_HIGH_CLR:       cfg.mr_high_clr = data;
                default: ;
            endcase
        endfunction

        // a floating clock pin reads as the idle level
        function t_level as_clock(t_level v, t_level idle);
            return (v == LVL_FLOAT) ? idle : v;
        endfunction

        function void note_sample(t_in_item s);
            t_level    act;
            t_level    idle;
            t_level    sclk;
            t_level    lclk;
            t_level    mr_on;
            t_level    oe_on;
            t_level    lv [8];
            t_out_item r;
            act   = cfg.clock_active_high ? LVL_HIGH : LVL_LOW;
            idle  = cfg.clock_active_high ? LVL_LOW : LVL_HIGH;
            sclk  = as_clock(s.srclk_level, idle);
            lclk  = as_clock(s.rclk_level, idle);
            mr_on = cfg.mr_high_clr ? LVL_HIGH : LVL_LOW;
            oe_on = cfg.oe_high_en ? LVL_HIGH : LVL_LOW;

            // latch sees the shift value from before this sample
            if (lclk == act && as_clock(prev_store_clk, idle) == idle) begin
                latch_bits   = shift_bits;
                latch_x_mask = shift_x_mask;
            end else if (lclk == LVL_CONFLICT) begin
                latch_x_mask = '1;
            end

            if (s.mr_level == mr_on) begin
                shift_bits   = '0;
                shift_x_mask = '0;
            end else if (s.mr_level == LVL_CONFLICT || sclk == LVL_CONFLICT) begin
                shift_x_mask = '1;
            end else if (sclk == act && as_clock(prev_shift_clk, idle) == idle) begin
                shift_bits   = {shift_bits[6:0], s.ser_level == LVL_HIGH};
                shift_x_mask = {shift_x_mask[6:0], s.ser_level == LVL_CONFLICT};
            end
            prev_shift_clk = sclk;
            prev_store_clk = lclk;

            for (int i = 0; i < 8; i++) begin
                if (s.oe_level == LVL_CONFLICT)
                    lv[i] = LVL_CONFLICT;
                else if (s.oe_level != LVL_FLOAT && s.oe_level != oe_on)
                    lv[i] = LVL_FLOAT;
                else if (latch_x_mask[i])
                    lv[i] = LVL_CONFLICT;
                else
                    lv[i] = latch_bits[i] ? LVL_HIGH : LVL_LOW;
            end
            r.q0_level = lv[0];
            r.q1_level = lv[1];
            r.q2_level = lv[2];
            r.q3_level = lv[3];
            r.q4_level = lv[4];
            r.q5_level = lv[5];
            r.q6_level = lv[6];
            r.q7_level = lv[7];
            r.serial_out_level = shift_x_mask[7] ? LVL_CONFLICT
                                                 : (shift_bits[7] ? LVL_HIGH : LVL_LOW);
            expected_levels.push_back(r);
        endfunction

        function void check_result(t_out_item got);
            t_out_item  want;
            logic [17:0] w;
            logic [17:0] g;
            bit          bad;
            string       names [9];
            names = '{"q0", "q1", "q2", "q3", "q4", "q5", "q6", "q7", "serial_out"};
            if (expected_levels.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result %h with nothing pending", got);
                mismatches++;
                return;
            end
            want = expected_levels.pop_front();
            w = want;
            g = got;
            bad = 1'b0;
            for (int k = 0; k < 9; k++) begin
                if (g[17 - 2 * k -: 2] !== w[17 - 2 * k -: 2]) begin
                    if (mismatches < 10)
                        $display("mismatch on %s: expected %0d got %0d",
                                 names[k], w[17 - 2 * k -: 2], g[17 - 2 * k -: 2]);
                    bad = 1'b1;
                end
            end
            if (bad)
                mismatches++;
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    t_cfg_index i_cfg_index;
    logic       i_cfg_data;
    logic       i_valid;
    logic       o_ready;
    t_in_item   i_item;
    logic       o_valid;
    logic       i_ready;
    t_out_item  o_result;

    level_scoreboard board;
    t_cfg            cur_cfg;        // polarities the stimulus is shaped for
    int              samples_sent;
    int              cycle_count = 0;
    bit              tx_idle_on;
    bit              rx_idle_on;

    serial_in_latched_shift_register u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_result    (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    // monitor: every transfer is seen with the values from before the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                board.write_reg(i_cfg_index, i_cfg_data);
            if (i_valid && o_ready)
                board.note_sample(i_item);
            if (o_valid && i_ready)
                board.check_result(o_result);
        end
    end

    // result side: random stall before each transfer, with calm stretches in between
    initial begin
        int stall;
        rx_idle_on = 1'b1;
        i_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = rx_idle_on ? $urandom_range(0, 19) : 0;
            if (stall != 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            if ($urandom_range(0, 49) == 0)
                rx_idle_on = !rx_idle_on;
        end
    end

    function automatic t_in_item pins(t_level sc, t_level rc, t_level mr, t_level ser,
                                      t_level oe);
        t_in_item s;
        s.srclk_level = sc;
        s.rclk_level  = rc;
        s.mr_level    = mr;
        s.ser_level   = ser;
        s.oe_level    = oe;
        return s;
    endfunction

    function automatic t_level any_level();
        return t_level'($urandom_range(0, 3));
    endfunction

    // idle clock level, now and then left floating
    function automatic t_level idle_clock();
        if ($urandom_range(0, 3) == 0)
            return LVL_FLOAT;
        return cur_cfg.clock_active_high ? LVL_LOW : LVL_HIGH;
    endfunction

    // well-formed sample for the current polarities, random data and output enable, with a rare glitch
    function automatic t_in_item clean_sample(bit sclk_on, bit lclk_on, bit mr_on);
        t_in_item s;
        t_level   act;
        t_level   mr_act;
        t_level   oe_act;
        int       pick;
        act    = cur_cfg.clock_active_high ? LVL_HIGH : LVL_LOW;
        mr_act = cur_cfg.mr_high_clr ? LVL_HIGH : LVL_LOW;
        oe_act = cur_cfg.oe_high_en ? LVL_HIGH : LVL_LOW;
        s.srclk_level = sclk_on ? act : idle_clock();
        s.rclk_level  = lclk_on ? act : idle_clock();
        if (mr_on)
            s.mr_level = mr_act;
        else if ($urandom_range(0, 7) == 0)
            s.mr_level = LVL_FLOAT;
        else
            s.mr_level = (mr_act == LVL_HIGH) ? LVL_LOW : LVL_HIGH;
        pick = $urandom_range(0, 19);
        if (pick < 9)
            s.ser_level = LVL_LOW;
        else if (pick < 18)
            s.ser_level = LVL_HIGH;
        else if (pick == 18)
            s.ser_level = LVL_FLOAT;
        else
            s.ser_level = LVL_CONFLICT;
        pick = $urandom_range(0, 15);
        if (pick < 11)
            s.oe_level = oe_act;
        else if (pick < 13)
            s.oe_level = LVL_FLOAT;
        else if (pick < 15)
            s.oe_level = (oe_act == LVL_HIGH) ? LVL_LOW : LVL_HIGH;
        else
            s.oe_level = LVL_CONFLICT;
        // rare glitch on one pin
        if ($urandom_range(0, 31) == 0) begin
            case ($urandom_range(0, 4))
                0: s.srclk_level = any_level();
                1: s.rclk_level  = any_level();
                2: s.mr_level    = any_level();
                3: s.ser_level   = any_level();
                default: s.oe_level = any_level();
            endcase
        end
        return s;
    endfunction

    // one sample transfer; valid stays up across back-to-back samples
    task automatic send_sample(input t_in_item s);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 19) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= s;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        samples_sent++;
        if ($urandom_range(0, 49) == 0)
            tx_idle_on = !tx_idle_on;
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
    endtask

    // full register set, the spare index first; only while the block is idle
    task automatic apply_config(input t_cfg c);
        write_reg(CFG_SPARE_INDEX, 1'($urandom_range(0, 1)));
        write_reg(CFG_CLOCK_ACTIVE_HIGH, c.clock_active_high);
        write_reg(CFG_OE_HIGH_EN, c.oe_high_en);
        write_reg(CFG_MR_HIGH_CLR, c.mr_high_clr);
        i_cfg_valid <= 1'b0;
        cur_cfg = c;
    endtask

    // wait until every predicted result came back, then idle before returning
    task automatic drain();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (board.pending() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // serial load of a few bits, then usually a storage pulse
    task automatic send_byte_load();
        int nbits;
        nbits = $urandom_range(1, 10);
        if ($urandom_range(0, 5) == 0)
            send_sample(clean_sample(1'b0, 1'b0, 1'b1));
        for (int i = 0; i < nbits; i++) begin
            send_sample(clean_sample(1'b0, 1'b0, 1'b0));
            // now and then shift and store on the same sample
            send_sample(clean_sample(1'b1, $urandom_range(0, 7) == 0, 1'b0));
        end
        if ($urandom_range(0, 3) != 0) begin
            send_sample(clean_sample(1'b0, 1'b1, 1'b0));
            send_sample(clean_sample(1'b0, 1'b0, 1'b0));
        end
    endtask

    task automatic send_random(input int count);
        int target;
        int burst;
        target = samples_sent + count;
        while (samples_sent < target) begin
            if ($urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 6);
                repeat (burst)
                    send_sample(pins(any_level(), any_level(), any_level(), any_level(),
                                     any_level()));
            end else begin
                send_byte_load();
            end
        end
    endtask

    // directed samples under the reset polarities: rising clocks, low OE and MR active
    task automatic send_directed();
        send_sample(pins(LVL_LOW, LVL_LOW, LVL_LOW, LVL_LOW, LVL_LOW));
        send_sample(pins(LVL_CONFLICT, LVL_CONFLICT, LVL_CONFLICT, LVL_CONFLICT,
                         LVL_CONFLICT));
        send_sample(pins(LVL_LOW, LVL_LOW, LVL_HIGH, LVL_HIGH, LVL_LOW));
        // shift in high, conflict, floating data
        send_sample(pins(LVL_HIGH, LVL_LOW, LVL_HIGH, LVL_HIGH, LVL_LOW));
        send_sample(pins(LVL_LOW, LVL_LOW, LVL_HIGH, LVL_CONFLICT, LVL_LOW));
        send_sample(pins(LVL_HIGH, LVL_LOW, LVL_HIGH, LVL_CONFLICT, LVL_LOW));
        send_sample(pins(LVL_FLOAT, LVL_LOW, LVL_HIGH, LVL_FLOAT, LVL_LOW));
        send_sample(pins(LVL_HIGH, LVL_LOW, LVL_HIGH, LVL_FLOAT, LVL_LOW));
        // storage edge with known and unknown bits
        send_sample(pins(LVL_LOW, LVL_HIGH, LVL_HIGH, LVL_LOW, LVL_LOW));
        // shift clock conflict, outputs enabled by floating OE
        send_sample(pins(LVL_CONFLICT, LVL_LOW, LVL_HIGH, LVL_HIGH, LVL_FLOAT));
        // conflict to active is no edge; OE at disabling level
        send_sample(pins(LVL_HIGH, LVL_FLOAT, LVL_HIGH, LVL_HIGH, LVL_HIGH));
        // storage clock conflict, OE conflict
        send_sample(pins(LVL_LOW, LVL_CONFLICT, LVL_HIGH, LVL_LOW, LVL_CONFLICT));
        send_sample(pins(LVL_LOW, LVL_HIGH, LVL_HIGH, LVL_LOW, LVL_LOW));
        // master reset conflict
        send_sample(pins(LVL_LOW, LVL_LOW, LVL_CONFLICT, LVL_LOW, LVL_LOW));
        // storage edge and master reset together
        send_sample(pins(LVL_LOW, LVL_HIGH, LVL_LOW, LVL_LOW, LVL_LOW));
        send_sample(pins(LVL_HIGH, LVL_LOW, LVL_HIGH, LVL_HIGH, LVL_LOW));
        send_sample(pins(LVL_LOW, LVL_LOW, LVL_HIGH, LVL_LOW, LVL_LOW));
        // shift and store on the same sample: latch takes the old shift value
        send_sample(pins(LVL_HIGH, LVL_HIGH, LVL_HIGH, LVL_LOW, LVL_LOW));
        send_sample(pins(LVL_FLOAT, LVL_FLOAT, LVL_FLOAT, LVL_FLOAT, LVL_FLOAT));
        // master reset wins over a shift edge
        send_sample(pins(LVL_HIGH, LVL_HIGH, LVL_LOW, LVL_HIGH, LVL_LOW));
        send_sample(pins(LVL_FLOAT, LVL_LOW, LVL_HIGH, LVL_HIGH, LVL_LOW));
    endtask

    initial begin
        t_cfg c;
        board = new();
        samples_sent = 0;
        tx_idle_on = 1'b1;
        cur_cfg.clock_active_high = 1'b1;
        cur_cfg.oe_high_en        = 1'b0;
        cur_cfg.mr_high_clr       = 1'b0;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_item      <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_CLOCK_ACTIVE_HIGH;
        i_cfg_data  <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_directed();
        drain();

        // every polarity set once (all low and all high among them), then random ones
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < 8)
                c = t_cfg'(p[2:0]);
            else
                c = t_cfg'(3'($urandom_range(0, 7)));
            apply_config(c);
            send_random(ITEMS_PER_PHASE);
            drain();
        end

        if (board.pending() != 0)
            $display("%0d results never arrived", board.pending());
        if (board.mismatches == 0 && board.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[filelist.f]
rtl/sisr_pkg.sv
rtl/sisr_core.sv
rtl/serial_in_latched_shift_register.sv
sim/serial_in_latched_shift_register_tb.sv
